// ----- hdl/pf_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers for the Playfair encryption block.
// No dependencies; pf_front, pf_fifo, pf_back and the top level import this package.
package pf_pkg;

    localparam int LETTER_W    = 5;
    localparam int COORD_W     = 3;
    localparam int SIDE        = 5;
    localparam int CELLS       = 25;
    localparam int LETTERS     = 26;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [LETTER_W-1:0] CODE_X = 5'd23;
    localparam logic [LETTER_W-1:0] CODE_Q = 5'd16;
    localparam logic [LETTER_W-1:0] CODE_J = 5'd9;

    typedef enum logic [1:0] {
        OP_KEY    = 2'd0,
        OP_FINISH = 2'd1,
        OP_MSG    = 2'd2,
        OP_END    = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t             opcode;
        logic [LETTER_W-1:0] letter;
    } item_t;

    typedef struct packed {
        logic [LETTER_W-1:0] cipher_letter;
        logic                last;
    } result_t;

    typedef enum logic [1:0] {
        CMD_PLACE   = 2'd0,
        CMD_FILL    = 2'd1,
        CMD_ENCRYPT = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [LETTER_W-1:0] letter_a;
        logic [LETTER_W-1:0] letter_b;
        logic                last;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_FILL,
        BK_READ_B,
        BK_LATCH_B,
        BK_READ_X,
        BK_EMIT_X,
        BK_EMIT_Y
    } back_state_t;

    // A letter code that may sit in the grid: A..Z without J
    function automatic logic usable(input logic [LETTER_W-1:0] l);
        return (l <= LETTER_W'(LETTERS - 1)) && (l != CODE_J);
    endfunction

    // Step a row or column by one, wrapping at the grid edge
    function automatic logic [COORD_W-1:0] coord_inc(input logic [COORD_W-1:0] c);
        return (c == COORD_W'(SIDE - 1)) ? '0 : c + COORD_W'(1);
    endfunction

    // Row-major cell index: row * 5 + col
    function automatic logic [LETTER_W-1:0] cell_index(input logic [COORD_W-1:0] row,
                                                       input logic [COORD_W-1:0] col);
        return (LETTER_W'(row) << 2) + LETTER_W'(row) + LETTER_W'(col);
    endfunction

endpackage

// ----- hdl/pf_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; read data holds while no read is issued.
module pf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AddrW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AddrW-1:0] wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AddrW-1:0] rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/pf_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts input transactions, pairs message letters and
// classifies each item into a back-end command. Depends on pf_pkg.
module pf_front
    import pf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    input  item_t item,
    output logic  item_stall,
    input  logic  full,
    output logic  push,
    output cmd_t  push_cmd
);

    logic [LETTER_W-1:0] pending_letter_reg, pending_letter_next;
    logic                pending_valid_reg, pending_valid_next;
    logic                accept;

    // Classify the accepted transaction and update the pairing state
    always_comb
    begin
        item_stall          = full;
        accept              = item_valid && !full;
        push                = 1'b0;
        push_cmd.kind       = CMD_PLACE;
        push_cmd.letter_a   = item.letter;
        push_cmd.letter_b   = CODE_X;
        push_cmd.last       = 1'b0;
        pending_letter_next = pending_letter_reg;
        pending_valid_next  = pending_valid_reg;

        if (accept)
        begin
            case (item.opcode)
                OP_KEY:
                begin
                    push = usable(item.letter);
                end
                OP_FINISH:
                begin
                    push          = 1'b1;
                    push_cmd.kind = CMD_FILL;
                end
                OP_MSG:
                begin
                    if (usable(item.letter))
                    begin
                        if (!pending_valid_reg)
                        begin
                            pending_letter_next = item.letter;
                            pending_valid_next  = 1'b1;
                        end
                        else if (pending_letter_reg == item.letter)
                        begin
                            // Doubled letter: pad, keep the second copy pending
                            push              = 1'b1;
                            push_cmd.kind     = CMD_ENCRYPT;
                            push_cmd.letter_b = (item.letter == CODE_X) ? CODE_Q : CODE_X;
                        end
                        else
                        begin
                            push               = 1'b1;
                            push_cmd.kind      = CMD_ENCRYPT;
                            push_cmd.letter_a  = pending_letter_reg;
                            push_cmd.letter_b  = item.letter;
                            pending_valid_next = 1'b0;
                        end
                    end
                end
                OP_END:
                begin
                    if (pending_valid_reg)
                    begin
                        push               = 1'b1;
                        push_cmd.kind      = CMD_ENCRYPT;
                        push_cmd.letter_a  = pending_letter_reg;
                        push_cmd.letter_b  = CODE_X;
                        push_cmd.last      = 1'b1;
                        pending_valid_next = 1'b0;
                    end
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    // Hold the lone letter waiting for its partner
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_letter_reg <= '0;
            pending_valid_reg  <= 1'b0;
        end
        else
        begin
            pending_letter_reg <= pending_letter_next;
            pending_valid_reg  <= pending_valid_next;
        end
    end

endmodule

// ----- hdl/pf_fifo.sv -----
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
// Depends on pf_pkg for the command type.
module pf_fifo
    import pf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t head,
    output logic empty
);

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    cmd_t            entry_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign full  = (count_reg == CntW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("command pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("command popped from an empty queue");
`endif

endmodule

// ----- hdl/pf_back.sv -----
`timescale 1ns / 1ps
// Back end: owns the key grid and carries out place, fill and encrypt
// commands. Depends on pf_pkg and pf_ram.
module pf_back
    import pf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    empty,
    input  cmd_t    head,
    output logic    pop,
    output logic    result_valid,
    output result_t result,
    input  logic    result_stall
);

    localparam int PosW = 2 * COORD_W;

    back_state_t         state_reg, state_next;
    logic [LETTER_W-1:0] key_reg, key_next;
    logic [LETTER_W-1:0] b_reg, b_next;
    logic                last_reg, last_next;
    logic [COORD_W-1:0]  ra_reg, ra_next, ca_reg, ca_next;
    logic [COORD_W-1:0]  rb_reg, rb_next, cb_reg, cb_next;
    logic [LETTER_W-1:0] y_idx_reg, y_idx_next;
    logic [LETTER_W-1:0] fill_reg;
    logic [COORD_W-1:0]  row_reg, col_reg;
    logic [LETTERS-1:0]  placed_reg;
    logic                result_valid_reg, result_valid_next;
    result_t             result_reg, result_next;

    logic                place_req, place_en;
    logic [LETTER_W-1:0] place_letter;
    logic                pos_rd_en, grid_rd_en;
    logic [LETTER_W-1:0] pos_rd_addr, grid_rd_addr;
    logic [PosW-1:0]     pos_rd_data;
    logic [LETTER_W-1:0] grid_rd_data;
    logic [LETTER_W-1:0] x_idx;
    logic                out_load, slot_free;
    logic [LETTER_W-1:0] out_letter;
    logic                out_last;

    // Letter -> {row, column}
    pf_ram #(
        .WIDTH (PosW),
        .DEPTH (LETTERS)
    ) u_pos_ram (
        .clk     (clk),
        .wr_en   (place_en),
        .wr_addr (place_letter),
        .wr_data ({row_reg, col_reg}),
        .rd_en   (pos_rd_en),
        .rd_addr (pos_rd_addr),
        .rd_data (pos_rd_data)
    );

    // Cell index -> letter
    pf_ram #(
        .WIDTH (LETTER_W),
        .DEPTH (CELLS)
    ) u_grid_ram (
        .clk     (clk),
        .wr_en   (place_en),
        .wr_addr (fill_reg),
        .wr_data (place_letter),
        .rd_en   (grid_rd_en),
        .rd_addr (grid_rd_addr),
        .rd_data (grid_rd_data)
    );

    assign place_en = place_req && usable(place_letter) && !placed_reg[place_letter]
                      && (fill_reg < LETTER_W'(CELLS));
    assign slot_free = !result_valid_reg || !result_stall;

    // Sequencer: next state and datapath controls
    always_comb
    begin
        state_next   = state_reg;
        key_next     = key_reg;
        b_next       = b_reg;
        last_next    = last_reg;
        ra_next      = ra_reg;
        ca_next      = ca_reg;
        rb_next      = rb_reg;
        cb_next      = cb_reg;
        y_idx_next   = y_idx_reg;
        pop          = 1'b0;
        place_req    = 1'b0;
        place_letter = head.letter_a;
        pos_rd_en    = 1'b0;
        pos_rd_addr  = head.letter_a;
        grid_rd_en   = 1'b0;
        grid_rd_addr = y_idx_reg;
        x_idx        = '0;
        out_load     = 1'b0;
        out_letter   = grid_rd_data;
        out_last     = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    case (head.kind)
                        CMD_PLACE:
                        begin
                            place_req = 1'b1;
                        end
                        CMD_FILL:
                        begin
                            key_next   = '0;
                            state_next = BK_FILL;
                        end
                        CMD_ENCRYPT:
                        begin
                            b_next     = head.letter_b;
                            last_next  = head.last;
                            pos_rd_en  = 1'b1;
                            state_next = BK_READ_B;
                        end
                        default:
                        begin
                            state_next = BK_IDLE;
                        end
                    endcase
                end
            end
            BK_FILL:
            begin
                // Sweep the alphabet, placing every letter still missing
                place_req    = 1'b1;
                place_letter = key_reg;
                key_next     = key_reg + LETTER_W'(1);
                if (key_reg == LETTER_W'(LETTERS - 1))
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_READ_B:
            begin
                ra_next     = pos_rd_data[PosW-1:COORD_W];
                ca_next     = pos_rd_data[COORD_W-1:0];
                pos_rd_en   = 1'b1;
                pos_rd_addr = b_reg;
                state_next  = BK_LATCH_B;
            end
            BK_LATCH_B:
            begin
                rb_next    = pos_rd_data[PosW-1:COORD_W];
                cb_next    = pos_rd_data[COORD_W-1:0];
                state_next = BK_READ_X;
            end
            BK_READ_X:
            begin
                // Same row, same column or rectangle rule
                if (ra_reg == rb_reg)
                begin
                    x_idx      = cell_index(ra_reg, coord_inc(ca_reg));
                    y_idx_next = cell_index(rb_reg, coord_inc(cb_reg));
                end
                else if (ca_reg == cb_reg)
                begin
                    x_idx      = cell_index(coord_inc(ra_reg), ca_reg);
                    y_idx_next = cell_index(coord_inc(rb_reg), cb_reg);
                end
                else
                begin
                    x_idx      = cell_index(ra_reg, cb_reg);
                    y_idx_next = cell_index(rb_reg, ca_reg);
                end
                grid_rd_en   = 1'b1;
                grid_rd_addr = x_idx;
                state_next   = BK_EMIT_X;
            end
            BK_EMIT_X:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    grid_rd_en = 1'b1;
                    state_next = BK_EMIT_Y;
                end
            end
            BK_EMIT_Y:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    out_last   = last_reg;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Output register: load a result, drop it once taken
    always_comb
    begin
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        if (out_load)
        begin
            result_next.cipher_letter = out_letter;
            result_next.last          = out_last;
            result_valid_next         = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= BK_IDLE;
            fill_reg         <= '0;
            row_reg          <= '0;
            col_reg          <= '0;
            placed_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            // Advance the fill position on every placement
            if (place_en)
            begin
                placed_reg[place_letter] <= 1'b1;
                fill_reg                 <= fill_reg + LETTER_W'(1);
                if (col_reg == COORD_W'(SIDE - 1))
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + COORD_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + COORD_W'(1);
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        b_reg      <= b_next;
        last_reg   <= last_next;
        ra_reg     <= ra_next;
        ca_reg     <= ca_next;
        rb_reg     <= rb_next;
        cb_reg     <= cb_next;
        y_idx_reg  <= y_idx_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= LETTER_W'(CELLS))
        else $error("fill position ran past the grid");

    a_fill_coords: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg < LETTER_W'(CELLS)) |-> (cell_index(row_reg, col_reg) == fill_reg))
        else $error("fill row and column out of step with fill position");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_EMIT_Y) |->
            ($past(state_reg) == BK_EMIT_X || $past(state_reg) == BK_EMIT_Y))
        else $error("second cipher letter without the first");
`endif

endmodule

// ----- hdl/playfair_encrypt_top.sv -----
`timescale 1ns / 1ps
// Playfair encryption block: front end, command queue and back end.
// Depends on pf_pkg, pf_front, pf_fifo and pf_back.
//
// Items come in on the item channel and cipher letters go out on the result
// channel, both valid/stall. The front end takes one item per cycle while the
// command queue has room and pairs message letters on the fly; the back end
// works one command at a time. A key letter is placed as it leaves the queue,
// a finish key sweeps over all 26 letter codes, and each encrypted pair is
// paced by the serial reads of the single-read-port position and grid RAMs
// (positions of both letters, then both cipher cells). Items that make no pair
// (first letter of a pair, unusable codes) never reach the queue. No clearing
// pass after reset.
module playfair_encrypt_top
    import pf_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  item_t   item,
    output logic    item_stall,
    output logic    result_valid,
    output result_t result,
    input  logic    result_stall
);

    logic push, full, pop, empty;
    cmd_t push_cmd, head;

    pf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_stall (item_stall),
        .full       (full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    pf_fifo #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    pf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (empty),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result),
        .result_stall (result_stall)
    );

endmodule

// ----- tb/sv/playfair_encrypt_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for playfair_encrypt_top: key setup, message pairing, cipher rules.
// Depends on pf_pkg and hdl/playfair_encrypt_top.sv; needs no files or arguments.
module playfair_encrypt_top_tb;
    import pf_pkg::*;

    localparam int MSG_ITEMS   = 1750;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int DRAIN_WAIT  = 64;

    // Track the grid and the open pair, and hold the cipher letters still owed
    class playfair_tracker;
        bit                  placed [LETTERS];
        int                  row_of [LETTERS];
        int                  col_of [LETTERS];
        logic [LETTER_W-1:0] grid [CELLS];
        int                  filled;
        logic [LETTER_W-1:0] held;
        bit                  held_ok;
        result_t             expected_cipher [$];
        int                  errors;
        int                  items_in;
        int                  letters_checked;
        int                  row_pairs;
        int                  col_pairs;
        int                  rect_pairs;

        function bit fits(logic [LETTER_W-1:0] l);
            return (l < LETTERS) && (l != CODE_J);
        endfunction

        function void place_letter(logic [LETTER_W-1:0] l);
            if (!fits(l) || placed[l] || filled >= CELLS)
                return;
            placed[l] = 1'b1;
            row_of[l] = filled / SIDE;
            col_of[l] = filled % SIDE;
            grid[filled] = l;
            filled++;
        endfunction

        // Apply the same-row, same-column or rectangle rule to one pair
        function void encipher_pair(logic [LETTER_W-1:0] a, logic [LETTER_W-1:0] b, bit fin);
            result_t first_out;
            result_t second_out;
            int      ra;
            int      ca;
            int      rb;
            int      cb;
            ra = row_of[a];
            ca = col_of[a];
            rb = row_of[b];
            cb = col_of[b];
            if (ra == rb)
            begin
                first_out.cipher_letter  = grid[ra * SIDE + (ca + 1) % SIDE];
                second_out.cipher_letter = grid[rb * SIDE + (cb + 1) % SIDE];
                row_pairs++;
            end
            else if (ca == cb)
            begin
                first_out.cipher_letter  = grid[((ra + 1) % SIDE) * SIDE + ca];
                second_out.cipher_letter = grid[((rb + 1) % SIDE) * SIDE + cb];
                col_pairs++;
            end
            else
            begin
                first_out.cipher_letter  = grid[ra * SIDE + cb];
                second_out.cipher_letter = grid[rb * SIDE + ca];
                rect_pairs++;
            end
            first_out.last  = 1'b0;
            second_out.last = fin;
            expected_cipher = {expected_cipher, first_out, second_out};
        endfunction

        // Note one accepted input transaction and predict its cipher letters
        function void take_item(item_t it);
            items_in++;
            case (it.opcode)
                OP_KEY:
                    place_letter(it.letter);
                OP_FINISH:
                    for (int k = 0; k < LETTERS; k++)
                        place_letter(LETTER_W'(k));
                OP_MSG:
                    if (fits(it.letter))
                    begin
                        if (!held_ok)
                        begin
                            held    = it.letter;
                            held_ok = 1'b1;
                        end
                        else if (held == it.letter)
                            encipher_pair(held, (held == CODE_X) ? CODE_Q : CODE_X, 1'b0);
                        else
                        begin
                            encipher_pair(held, it.letter, 1'b0);
                            held_ok = 1'b0;
                        end
                    end
                OP_END:
                    if (held_ok)
                    begin
                        encipher_pair(held, CODE_X, 1'b1);
                        held_ok = 1'b0;
                    end
                default:
                    ;
            endcase
        endfunction

        // Compare one output transaction against the oldest prediction
        function void check_letter(result_t got);
            result_t want;
            if (expected_cipher.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected cipher letter: expected none, actual %0d last %0b",
                         $time, got.cipher_letter, got.last);
                return;
            end
            want = expected_cipher.pop_front();
            letters_checked++;
            if (got.cipher_letter !== want.cipher_letter)
            begin
                errors++;
                $display("%0t: wrong cipher_letter: expected %0d, actual %0d",
                         $time, want.cipher_letter, got.cipher_letter);
            end
            if (got.last !== want.last)
            begin
                errors++;
                $display("%0t: wrong last: expected %0b, actual %0b",
                         $time, want.last, got.last);
            end
        endfunction
    endclass

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    item_t   item = '0;
    logic    item_stall;
    logic    result_valid;
    result_t result;
    logic    result_stall = 1'b0;

    playfair_tracker book;
    bit              calm;
    int              cycles;
    int              stall_left;

    playfair_encrypt_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item         (item),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result       (result),
        .result_stall (result_stall)
    );

    always #1 clk = ~clk;

    // Idle length: mostly zero or short, now and then long; none in calm stretches
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Pick any letter that may sit in the grid
    function automatic logic [LETTER_W-1:0] any_letter();
        logic [LETTER_W-1:0] l;
        do
            l = LETTER_W'($urandom_range(0, LETTERS - 1));
        while (l == CODE_J);
        return l;
    endfunction

    // Offer one input transaction after a random gap and hold it until accepted
    task automatic send_item(input opcode_t op, input logic [LETTER_W-1:0] l);
        item_t it;
        int    gap;
        it.opcode = op;
        it.letter = l;
        gap = idle_len();
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        book.take_item(it);
    endtask

    // Stall the result side in random bursts
    always @(posedge clk)
    begin : stall_gen
        int n;
        if (stall_left != 0)
            stall_left <= stall_left - 1;
        else
        begin
            n = idle_len();
            result_stall <= (n != 0);
            stall_left   <= (n != 0) ? n - 1 : 0;
        end
    end

    // Check every accepted output transaction
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            book.check_letter(result);
    end

    // Guard against a hang
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d cipher letters still owed",
                     cycles, book.expected_cipher.size());
            $display("playfair_encrypt_top: mismatch");
            $finish;
        end
    end

    initial
    begin : stimulus
        int                  key_len;
        int                  sent;
        int                  r;
        int                  k;
        logic [LETTER_W-1:0] l;
        book = new();
        calm = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: ignored items before the key, with field extremes
        send_item(OP_END, 5'd31);
        send_item(OP_MSG, CODE_J);
        send_item(OP_MSG, 5'd26);
        send_item(OP_KEY, 5'd31);
        send_item(OP_KEY, CODE_J);
        send_item(OP_KEY, 5'd26);

        // Random key, repeats and unusable codes included
        key_len = $urandom_range(0, 30);
        for (int i = 0; i < key_len; i++)
            send_item(OP_KEY, LETTER_W'($urandom_range(0, 31)));

        // Open a pair, then add key letters and finish the key once the message has started
        send_item(OP_MSG, any_letter());
        send_item(OP_KEY, any_letter());
        send_item(OP_KEY, 5'd25);
        send_item(OP_FINISH, 5'd31);
        send_item(OP_FINISH, 5'd0);
        send_item(OP_KEY, 5'd0);

        // Doubled letter, doubled X, lone final X, end with nothing open
        send_item(OP_MSG, book.held);
        send_item(OP_MSG, 5'd0);
        if (book.held_ok)
            send_item(OP_END, 5'd0);
        send_item(OP_MSG, CODE_X);
        send_item(OP_MSG, CODE_X);
        send_item(OP_END, 5'd0);
        send_item(OP_END, 5'd0);

        // Same row with wrap, same column with wrap, rectangle
        send_item(OP_MSG, book.grid[0]);
        send_item(OP_MSG, book.grid[SIDE - 1]);
        send_item(OP_MSG, book.grid[0]);
        send_item(OP_MSG, book.grid[CELLS - SIDE]);
        send_item(OP_MSG, book.grid[SIDE + 1]);
        send_item(OP_MSG, book.grid[3 * SIDE + 3]);

        // Unusable letter inside an open pair, then close it
        send_item(OP_MSG, 5'd25);
        send_item(OP_MSG, CODE_J);
        send_item(OP_MSG, 5'd0);

        // Random message: mostly letters biased toward rows, columns and doubles
        sent = 0;
        while (sent < MSG_ITEMS)
        begin
            if (sent % 250 == 0)
                calm = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 80)
            begin
                l = any_letter();
                if (book.held_ok)
                begin
                    k = $urandom_range(0, 9);
                    if (k < 2)
                        l = book.held;
                    else if (k < 4)
                        l = book.grid[book.row_of[book.held] * SIDE + $urandom_range(0, SIDE - 1)];
                    else if (k < 6)
                        l = book.grid[$urandom_range(0, SIDE - 1) * SIDE + book.col_of[book.held]];
                    else if (k < 7)
                        l = CODE_X;
                end
                send_item(OP_MSG, l);
            end
            else if (r < 90)
                send_item(OP_END, LETTER_W'($urandom_range(0, 31)));
            else if (r < 95)
            begin
                l = ($urandom_range(0, 1) != 0) ? CODE_J : LETTER_W'($urandom_range(26, 31));
                send_item(OP_MSG, l);
            end
            else if (r < 98)
                send_item(OP_KEY, LETTER_W'($urandom_range(0, 31)));
            else
                send_item(OP_FINISH, LETTER_W'($urandom_range(0, 31)));
            sent++;
        end
        calm = 1'b0;
        item_valid <= 1'b0;

        // Drain, then watch for stray output
        while (book.expected_cipher.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d input transactions and %0d cipher letters",
                 book.items_in, book.letters_checked);
        $display("pairs by rule: same row %0d, same column %0d, rectangle %0d",
                 book.row_pairs, book.col_pairs, book.rect_pairs);
        if (book.errors == 0)
            $display("playfair_encrypt_top: match");
        else
            $display("playfair_encrypt_top: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/pf_pkg.sv
hdl/pf_ram.sv
hdl/pf_front.sv
hdl/pf_fifo.sv
hdl/pf_back.sv
hdl/playfair_encrypt_top.sv
tb/sv/playfair_encrypt_top_tb.sv
